// ----- hdl/led_linear_fade_top_defines.svh -----
// assertion macros shared by the led fade rtl
`ifndef LED_LINEAR_FADE_TOP_DEFINES_SVH
`define LED_LINEAR_FADE_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define LLF_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define LLF_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- hdl/llf_pkg.sv -----
// shared types and constants for the led fade block
`timescale 1ns / 1ps
`default_nettype none
package llf_pkg;
    localparam int LED_NUM = 4;
    localparam int LIDX_W = (LED_NUM > 1) ? $clog2(LED_NUM) : 1;
    localparam logic [7:0] FULL_SCALE = 8'd255;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_STOP = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    localparam logic [0:0] REG_BRIGHTNESS = 1'b0;

    typedef logic [7:0] level_t;
    typedef level_t [LED_NUM-1:0] level_vec_t;

    // request from the sequencer to the lanes
    typedef struct packed {
        logic        go;
        logic        full;
        logic [15:0] elapsed;
        logic [15:0] duration;
        logic [7:0]  brightness;
    } lane_req_t;
endpackage
`default_nettype wire

// ----- hdl/led_linear_fade_top.sv -----
// Linear LED crossfade with APB brightness register.
// Input channel in_valid/in_stall carries cmd, target_0..3, duration_ms:
// cmd tick advances an active fade one step, load starts a new fade from the
// current levels, stop ends the fade. Every transaction gives exactly one
// result on out_valid/out_stall: level_0..3 and step_done.
// A load or active tick inside the fade passes the issue register, the
// bit-serial divider in each lane, the scale step and the result register;
// one that ends the fade skips the divider, and other commands go straight
// to the result register. A new transaction is taken the cycle after the
// previous result has left, so transactions never overlap.
// The four lanes run in parallel, each with its own restoring divider.
// While the receiver stalls the result is held and input stays stalled.
// Reset clears levels and fade state; brightness returns to 255.
// Brightness (address 0) is to be written through APB only while idle;
// the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module led_linear_fade_top
    import llf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  target_0,
    input  wire logic [7:0]  target_1,
    input  wire logic [7:0]  target_2,
    input  wire logic [7:0]  target_3,
    input  wire logic [15:0] duration_ms,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       level_0,
    output logic [7:0]       level_1,
    output logic [7:0]       level_2,
    output logic [7:0]       level_3,
    output logic             step_done
);
    logic [7:0]  bright_reg;
    lane_req_t   req;
    level_vec_t  targets, start_q, target_q, lane_levels, levels;
    logic [LED_NUM-1:0] lane_done;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bright_reg <= FULL_SCALE;
        else if (psel && penable && pwrite && paddr == REG_BRIGHTNESS)
            bright_reg <= pwdata[7:0];
    end
    assign prdata = (paddr == REG_BRIGHTNESS) ? {24'd0, bright_reg} : 32'd0;

    assign targets = {target_3, target_2, target_1, target_0};

    llf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .targets(targets), .duration_ms(duration_ms),
        .brightness(bright_reg), .req(req), .start_q(start_q), .target_q(target_q),
        .lanes_done(&lane_done), .lane_levels(lane_levels), .out_valid(out_valid),
        .out_stall(out_stall), .levels(levels), .step_done(step_done)
    );

    for (genvar g = 0; g < LED_NUM; g++)
    begin : g_lane
        llf_lane u_lane (
            .clk(clk), .rst_n(rst_n), .req(req), .start_level(start_q[g]),
            .target_level(target_q[g]), .done(lane_done[g]), .level(lane_levels[g])
        );
    end

    assign level_0 = levels[0];
    assign level_1 = levels[1];
    assign level_2 = levels[2];
    assign level_3 = levels[3];
endmodule
`default_nettype wire

// ----- hdl/llf_lane.sv -----
// one led lane: fraction divide then brightness scaling
`timescale 1ns / 1ps
`default_nettype none
`include "led_linear_fade_top_defines.svh"
module llf_lane
    import llf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire lane_req_t req,
    input  wire level_t    start_level,
    input  wire level_t    target_level,
    output logic           done,
    output level_t         level
);
    typedef enum logic [1:0] {L_IDLE, L_DIV, L_SCALE} lstate_t;

    lstate_t     state_reg;
    logic [4:0]  cnt_reg;
    logic [23:0] num_reg;
    logic [15:0] quo_reg;
    logic [16:0] rem_reg;
    logic [15:0] den_reg;
    logic        neg_reg;
    level_t      start_reg;
    level_t      level_reg;
    logic        done_reg;

    logic [16:0] rem_sh;
    logic [8:0]  lvl;
    logic [15:0] prod;
    logic [16:0] prod_q;

    always_comb
    begin
        rem_sh = {rem_reg[15:0], num_reg[23]};
        lvl = neg_reg ? ({1'b0, start_reg} - {1'b0, quo_reg[7:0]})
                      : ({1'b0, start_reg} + {1'b0, quo_reg[7:0]});
        prod = lvl[7:0] * req.brightness;
        // divide by 255: (p + 1 + (p >> 8)) >> 8 is exact for 16-bit products
        prod_q = ({1'b0, prod} + 17'd1 + {9'd0, prod[15:8]}) >> 8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= state_reg == L_SCALE;
            case (state_reg)
                L_IDLE:
                begin
                    if (req.go)
                    begin
                        start_reg <= req.full ? target_level : start_level;
                        neg_reg   <= target_level < start_level;
                        num_reg   <= (target_level >= start_level
                            ? 8'(target_level - start_level)
                            : 8'(start_level - target_level)) * req.elapsed;
                        den_reg   <= req.duration;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= req.full ? L_SCALE : L_DIV;
                    end
                end
                L_DIV:
                begin
                    // one quotient bit per cycle
                    num_reg <= {num_reg[22:0], 1'b0};
                    if (rem_sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, den_reg};
                        quo_reg <= {quo_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[14:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd23)
                        state_reg <= L_SCALE;
                end
                L_SCALE:
                begin
                    level_reg <= prod_q[7:0];
                    state_reg <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign level = level_reg;

    `LLF_ASSERT_NEXT(a_go_leaves_idle, clk, rst_n, req.go && state_reg == L_IDLE,
        state_reg != L_IDLE)
    `LLF_ASSERT_IMP(a_div_count, clk, rst_n, state_reg == L_DIV, cnt_reg <= 5'd23)
    `LLF_ASSERT_NEXT(a_scale_done, clk, rst_n, state_reg == L_SCALE, done_reg)
endmodule
`default_nettype wire

// ----- hdl/llf_ctrl.sv -----
// fade sequencer: command decode, fade state and result register
`timescale 1ns / 1ps
`default_nettype none
`include "led_linear_fade_top_defines.svh"
module llf_ctrl
    import llf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] cmd,
    input  wire level_vec_t targets,
    input  wire logic [15:0] duration_ms,
    input  wire logic [7:0] brightness,
    output lane_req_t       req,
    output level_vec_t      start_q,
    output level_vec_t      target_q,
    input  wire logic       lanes_done,
    input  wire level_vec_t lane_levels,
    output logic            out_valid,
    input  wire logic       out_stall,
    output level_vec_t      levels,
    output logic            step_done
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;

    state_t      state_reg;
    level_vec_t  start_reg, target_reg, out_reg;
    logic [15:0] elapsed_reg, dur_reg;
    logic        active_reg, done_reg, go_reg, full_reg;
    logic        accept;
    logic        go_next;
    logic [15:0] el_next;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;
    assign el_next  = (elapsed_reg < dur_reg) ? elapsed_reg + 16'd1 : elapsed_reg;
    assign go_next  = accept && (cmd_t'(cmd) == CMD_LOAD
                                 || (cmd_t'(cmd) == CMD_TICK && active_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            start_reg   <= '0;
            target_reg  <= '0;
            out_reg     <= '0;
            elapsed_reg <= '0;
            dur_reg     <= '0;
            active_reg  <= 1'b0;
            done_reg    <= 1'b0;
            go_reg      <= 1'b0;
            full_reg    <= 1'b0;
        end
        else
        begin
            go_reg <= go_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd_t'(cmd))
                            CMD_LOAD:
                            begin
                                start_reg   <= out_reg;
                                target_reg  <= targets;
                                dur_reg     <= duration_ms;
                                elapsed_reg <= '0;
                                full_reg    <= duration_ms == 16'd0;
                                active_reg  <= duration_ms != 16'd0;
                                done_reg    <= duration_ms == 16'd0;
                                state_reg   <= S_RUN;
                            end
                            CMD_TICK:
                            begin
                                if (active_reg)
                                begin
                                    elapsed_reg <= el_next;
                                    full_reg    <= el_next >= dur_reg;
                                    active_reg  <= el_next < dur_reg;
                                    done_reg    <= el_next >= dur_reg;
                                    state_reg   <= S_RUN;
                                end
                                else
                                begin
                                    done_reg  <= 1'b0;
                                    state_reg <= S_OUT;
                                end
                            end
                            CMD_STOP:
                            begin
                                active_reg <= 1'b0;
                                done_reg   <= 1'b0;
                                state_reg  <= S_OUT;
                            end
                            default:
                            begin
                                done_reg  <= 1'b0;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RUN:
                begin
                    if (lanes_done)
                    begin
                        out_reg   <= lane_levels;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        req.go         = go_reg;
        req.full       = full_reg;
        req.elapsed    = elapsed_reg;
        req.duration   = dur_reg;
        req.brightness = brightness;
    end

    assign start_q   = start_reg;
    assign target_q  = target_reg;
    assign out_valid = state_reg == S_OUT;
    assign levels    = out_reg;
    assign step_done = done_reg;

    `LLF_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !accept)
    `LLF_ASSERT_IMP(a_elapsed_bound, clk, rst_n, 1'b1, elapsed_reg <= dur_reg)
    `LLF_ASSERT_NEXT(a_hold_output, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_reg))
endmodule
`default_nettype wire

// ----- tb/led_linear_fade_top_tb.sv -----
// self-checking testbench for the led linear crossfade block
`timescale 1ns / 1ps
module led_linear_fade_top_tb;
    import llf_pkg::*;

    localparam int RUN_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        level_vec_t lv;
        logic       done;
    } fade_result_t;

    class fade_scoreboard;
        logic [7:0]   bright;
        level_vec_t   start_lv;
        level_vec_t   target_lv;
        level_vec_t   drive_lv;
        logic [15:0]  elapsed_ms;
        logic [15:0]  fade_len;
        logic         fading;
        fade_result_t pending[$];
        int           errors;

        function new();
            bright = FULL_SCALE;
            start_lv = '0;
            target_lv = '0;
            drive_lv = '0;
            elapsed_ms = '0;
            fade_len = '0;
            fading = 1'b0;
            errors = 0;
        endfunction

        function void compute_levels();
            int unsigned s;
            int unsigned t;
            int unsigned lvl;
            for (int k = 0; k < LED_NUM; k++)
            begin
                s = start_lv[k];
                t = target_lv[k];
                if (fade_len == 0 || elapsed_ms >= fade_len)
                    lvl = t;
                else if (t >= s)
                    lvl = s + ((t - s) * elapsed_ms) / fade_len;
                else
                    lvl = s - ((s - t) * elapsed_ms) / fade_len;
                drive_lv[k] = 8'((lvl * bright) / FULL_SCALE);
            end
        endfunction

        function logic finish_check();
            if (elapsed_ms >= fade_len)
            begin
                fading = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_input(cmd_t c, level_vec_t tgt, logic [15:0] dur);
            fade_result_t r;
            r.done = 1'b0;
            if (c == CMD_LOAD)
            begin
                start_lv = drive_lv;
                target_lv = tgt;
                fade_len = dur;
                elapsed_ms = '0;
                fading = 1'b1;
                compute_levels();
                r.done = finish_check();
            end
            else if (c == CMD_TICK)
            begin
                if (fading)
                begin
                    if (elapsed_ms < fade_len)
                        elapsed_ms = elapsed_ms + 16'd1;
                    compute_levels();
                    r.done = finish_check();
                end
            end
            else if (c == CMD_STOP)
                fading = 1'b0;
            r.lv = drive_lv;
            pending.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(level_vec_t lv, logic done);
            fade_result_t r;
            if (pending.size() == 0)
            begin
                report("unexpected transaction", 0, 0);
                return;
            end
            r = pending.pop_front();
            for (int k = 0; k < LED_NUM; k++)
                if (lv[k] !== r.lv[k])
                    report($sformatf("level_%0d", k), lv[k], r.lv[k]);
            if (done !== r.done)
                report("step_done", done, r.done);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_TICK;
    logic [7:0]  target_0 = '0;
    logic [7:0]  target_1 = '0;
    logic [7:0]  target_2 = '0;
    logic [7:0]  target_3 = '0;
    logic [15:0] duration_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  level_0;
    logic [7:0]  level_1;
    logic [7:0]  level_2;
    logic [7:0]  level_3;
    logic        step_done;

    fade_scoreboard sb = new();
    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  cycles = 0;

    led_linear_fade_top dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver side: random stall, or a long hold when asked
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result({level_3, level_2, level_1, level_0}, step_done);

    // starts and ends at a falling edge
    task send(cmd_t c, level_vec_t tgt, logic [15:0] dur);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cmd <= c;
        target_0 <= tgt[0];
        target_1 <= tgt[1];
        target_2 <= tgt[2];
        target_3 <= tgt[3];
        duration_ms <= dur;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(c, tgt, dur);
        @(negedge clk);
    endtask

    task write_brightness(logic [7:0] b);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_BRIGHTNESS;
        pwdata <= {24'd0, b};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.bright = b;
        @(negedge clk);
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function level_vec_t rand_targets();
        level_vec_t v;
        for (int k = 0; k < LED_NUM; k++)
            case ($urandom_range(3))
                0: v[k] = 8'd0;
                1: v[k] = 8'd255;
                default: v[k] = 8'($urandom);
            endcase
        return v;
    endfunction

    task random_fades(int n_items);
        int sent;
        int n_ticks;
        logic [15:0] dur;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                // noise: random tick, load, stop or unused command
                send(cmd_t'($urandom_range(3)), level_vec_t'({$urandom, $urandom}),
                     16'($urandom));
                sent++;
                continue;
            end
            case ($urandom_range(19))
                0: dur = 16'($urandom);
                1, 2, 3: dur = 16'($urandom_range(7, 30));
                default: dur = 16'($urandom_range(0, 6));
            endcase
            send(CMD_LOAD, rand_targets(), dur);
            sent++;
            n_ticks = (dur > 30) ? $urandom_range(1, 12) : dur + $urandom_range(0, 1);
            for (int i = 0; i < n_ticks; i++)
            begin
                if ($urandom_range(39) == 0)
                    send(CMD_STOP, '0, '0);
                else
                    send(CMD_TICK, level_vec_t'({$urandom, $urandom}), 16'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: load extremes, instant fade, idle tick, stop, unused command
        send(CMD_TICK, '0, '0);
        send(CMD_LOAD, {8'd255, 8'd255, 8'd255, 8'd255}, 16'd0);
        send(CMD_LOAD, {8'd0, 8'd255, 8'd0, 8'd128}, 16'd3);
        repeat (3) send(CMD_TICK, '0, '0);
        send(CMD_TICK, '0, '0);
        send(CMD_LOAD, {8'd255, 8'd0, 8'd255, 8'd1}, 16'hFFFF);
        send(CMD_TICK, '0, 16'hFFFF);
        send(CMD_TICK, {8'hFF, 8'hFF, 8'hFF, 8'hFF}, 16'hFFFF);
        send(CMD_STOP, '0, '0);
        send(CMD_TICK, '0, '0);
        send(CMD_NONE, {8'hAA, 8'h55, 8'hFF, 8'h00}, 16'h5555);
        send(CMD_LOAD, {8'd10, 8'd20, 8'd30, 8'd40}, 16'd1);
        send(CMD_TICK, '0, '0);
        drain();

        write_brightness(8'd0);
        idle_pct = 50;
        send(CMD_LOAD, {8'd200, 8'd100, 8'd50, 8'd255}, 16'd2);
        random_fades(220);
        drain();

        write_brightness(8'd1);
        idle_pct = 0;
        stall_pct = 50;
        random_fades(220);
        drain();

        write_brightness(8'($urandom_range(2, 254)));
        idle_pct = 8;
        stall_pct = 8;
        hold_req = 1'b1;
        random_fades(220);
        drain();

        write_brightness(8'd255);
        idle_pct = 0;
        stall_pct = 0;
        random_fades(220);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
